FILE: src/lnx_pkg.sv
package lnx_pkg;

    // Width of one Q16.16 coordinate.
    localparam int unsigned XW = 32;
    // Magnitude width of the widest dividend: |cross(W,D2)| * |D1 component|.
    localparam int unsigned NW = 98;
    // Magnitude width of the determinant.
    localparam int unsigned DW = 65;
    // Quotient bits produced by the divider; larger quotients saturate anyway.
    localparam int unsigned QB = 32;
    // Register stages in front of the divider, in the divider, and behind it.
    localparam int unsigned FRONT_STAGES = 7;
    localparam int unsigned BACK_STAGES  = 2;
    localparam int unsigned NSTG         = FRONT_STAGES + QB + BACK_STAGES;
    // Dividend lanes.
    localparam int unsigned LANES  = 4;
    localparam int unsigned LANE_T = 0;
    localparam int unsigned LANE_S = 1;
    localparam int unsigned LANE_X = 2;
    localparam int unsigned LANE_Y = 3;

    localparam logic [XW-1:0] MINUS_ONE_Q16 = 32'hFFFF_0000;
    localparam logic [XW-1:0] Q_MAX         = 32'h7FFF_FFFF;
    localparam logic [XW-1:0] Q_MIN         = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_INTERSECT = 2'd0,
        ST_EQUAL     = 2'd1,
        ST_APART     = 2'd2
    } t_status;

    // Payload that travels through the divider stages.
    typedef struct packed {
        logic [LANES-1:0][NW-1:0] rem;
        logic [LANES-1:0][QB-1:0] quo;
        logic [LANES-1:0]         ovf;
        logic [LANES-1:0]         neg;
        logic [DW-1:0]            dvs;
        logic [XW-1:0]            p1x;
        logic [XW-1:0]            p1y;
        logic                     det_zero;
        logic                     nums_zero;
    } t_div;

    // One finished result.
    typedef struct packed {
        t_status       status;
        logic [XW-1:0] first_factor;
        logic [XW-1:0] second_factor;
        logic [XW-1:0] hit_x;
        logic [XW-1:0] hit_y;
    } t_res;

endpackage

FILE: src/lnx_if.sv
interface lnx_in_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  first_point_x;
    logic signed [31:0]  first_point_y;
    logic signed [31:0]  first_dir_x;
    logic signed [31:0]  first_dir_y;
    logic signed [31:0]  second_point_x;
    logic signed [31:0]  second_point_y;
    logic signed [31:0]  second_dir_x;
    logic signed [31:0]  second_dir_y;

    modport source (
        output valid, first_point_x, first_point_y, first_dir_x, first_dir_y,
               second_point_x, second_point_y, second_dir_x, second_dir_y,
        input  ready
    );
    modport sink (
        input  valid, first_point_x, first_point_y, first_dir_x, first_dir_y,
               second_point_x, second_point_y, second_dir_x, second_dir_y,
        output ready
    );
endinterface

interface lnx_out_if;
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic signed [31:0]  first_factor;
    logic signed [31:0]  second_factor;
    logic signed [31:0]  hit_x;
    logic signed [31:0]  hit_y;

    modport source (
        output valid, status, first_factor, second_factor, hit_x, hit_y,
        input  ready
    );
    modport sink (
        input  valid, status, first_factor, second_factor, hit_x, hit_y,
        output ready
    );
endinterface

FILE: src/lnx_front.sv
module lnx_front (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [31:0]  i_p1x,
    input  logic signed [31:0]  i_p1y,
    input  logic signed [31:0]  i_d1x,
    input  logic signed [31:0]  i_d1y,
    input  logic signed [31:0]  i_p2x,
    input  logic signed [31:0]  i_p2y,
    input  logic signed [31:0]  i_d2x,
    input  logic signed [31:0]  i_d2y,
    output lnx_pkg::t_div       o_div
);

    // Stage 0: offset between the two points.
    logic signed [32:0] r0_wx, r0_wy;
    logic signed [31:0] r0_d1x, r0_d1y, r0_d2x, r0_d2y, r0_p1x, r0_p1y;
    // Stage 1: the six products of the three cross products.
    logic signed [63:0] r1_dd_a, r1_dd_b;
    logic signed [64:0] r1_t_a, r1_t_b, r1_s_a, r1_s_b;
    logic signed [31:0] r1_d1x, r1_d1y, r1_p1x, r1_p1y;
    // Stage 2: determinant and both numerators.
    logic signed [64:0] r2_det;
    logic signed [65:0] r2_numt, r2_nums;
    logic signed [31:0] r2_d1x, r2_d1y, r2_p1x, r2_p1y;
    // Stage 3: magnitudes and quotient signs.
    logic [64:0] r3_det_mag;
    logic [65:0] r3_numt_mag, r3_nums_mag;
    logic [31:0] r3_d1x_mag, r3_d1y_mag, r3_p1x, r3_p1y;
    logic [3:0]  r3_neg;
    logic        r3_det_zero, r3_nums_zero;
    // Stage 4: partial products of the hit-point dividends.
    logic [64:0] r4_pp_xl, r4_pp_xh, r4_pp_yl, r4_pp_yh;
    logic [64:0] r4_det_mag;
    logic [65:0] r4_numt_mag, r4_nums_mag;
    logic [31:0] r4_p1x, r4_p1y;
    logic [3:0]  r4_neg;
    logic        r4_det_zero, r4_nums_zero;
    // Stage 5: dividends assembled.
    lnx_pkg::t_div r5_div;
    // Stage 6: overflow check, the divider's starting point.
    lnx_pkg::t_div r6_div;
    lnx_pkg::t_div n6_div;
    logic [lnx_pkg::NW-1:0] lim;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_wx  <= {i_p2x[31], i_p2x} - {i_p1x[31], i_p1x};
            r0_wy  <= {i_p2y[31], i_p2y} - {i_p1y[31], i_p1y};
            r0_d1x <= i_d1x;
            r0_d1y <= i_d1y;
            r0_d2x <= i_d2x;
            r0_d2y <= i_d2y;
            r0_p1x <= i_p1x;
            r0_p1y <= i_p1y;

            r1_dd_a <= r0_d1x * r0_d2y;
            r1_dd_b <= r0_d1y * r0_d2x;
            r1_t_a  <= r0_wx * r0_d2y;
            r1_t_b  <= r0_wy * r0_d2x;
            r1_s_a  <= r0_wx * r0_d1y;
            r1_s_b  <= r0_wy * r0_d1x;
            r1_d1x  <= r0_d1x;
            r1_d1y  <= r0_d1y;
            r1_p1x  <= r0_p1x;
            r1_p1y  <= r0_p1y;

            r2_det  <= r1_dd_a - r1_dd_b;
            r2_numt <= r1_t_a - r1_t_b;
            r2_nums <= r1_s_a - r1_s_b;
            r2_d1x  <= r1_d1x;
            r2_d1y  <= r1_d1y;
            r2_p1x  <= r1_p1x;
            r2_p1y  <= r1_p1y;

            r3_det_mag   <= r2_det[64] ? -r2_det : r2_det;
            r3_numt_mag  <= r2_numt[65] ? -r2_numt : r2_numt;
            r3_nums_mag  <= r2_nums[65] ? -r2_nums : r2_nums;
            r3_d1x_mag   <= r2_d1x[31] ? -r2_d1x : r2_d1x;
            r3_d1y_mag   <= r2_d1y[31] ? -r2_d1y : r2_d1y;
            r3_neg[lnx_pkg::LANE_T] <= r2_numt[65] ^ r2_det[64];
            r3_neg[lnx_pkg::LANE_S] <= r2_nums[65] ^ r2_det[64];
            r3_neg[lnx_pkg::LANE_X] <= r2_numt[65] ^ r2_d1x[31] ^ r2_det[64];
            r3_neg[lnx_pkg::LANE_Y] <= r2_numt[65] ^ r2_d1y[31] ^ r2_det[64];
            r3_det_zero  <= (r2_det == '0);
            r3_nums_zero <= (r2_nums == '0);
            r3_p1x       <= r2_p1x;
            r3_p1y       <= r2_p1y;

            r4_pp_xl     <= r3_numt_mag[32:0] * r3_d1x_mag;
            r4_pp_xh     <= r3_numt_mag[65:33] * r3_d1x_mag;
            r4_pp_yl     <= r3_numt_mag[32:0] * r3_d1y_mag;
            r4_pp_yh     <= r3_numt_mag[65:33] * r3_d1y_mag;
            r4_det_mag   <= r3_det_mag;
            r4_numt_mag  <= r3_numt_mag;
            r4_nums_mag  <= r3_nums_mag;
            r4_neg       <= r3_neg;
            r4_det_zero  <= r3_det_zero;
            r4_nums_zero <= r3_nums_zero;
            r4_p1x       <= r3_p1x;
            r4_p1y       <= r3_p1y;

            r5_div.rem[lnx_pkg::LANE_T] <= {16'b0, r4_numt_mag, 16'b0};
            r5_div.rem[lnx_pkg::LANE_S] <= {16'b0, r4_nums_mag, 16'b0};
            r5_div.rem[lnx_pkg::LANE_X] <= {r4_pp_xh, 33'b0} + {33'b0, r4_pp_xl};
            r5_div.rem[lnx_pkg::LANE_Y] <= {r4_pp_yh, 33'b0} + {33'b0, r4_pp_yl};
            r5_div.quo       <= '0;
            r5_div.ovf       <= '0;
            r5_div.neg       <= r4_neg;
            r5_div.dvs       <= r4_det_mag;
            r5_div.p1x       <= r4_p1x;
            r5_div.p1y       <= r4_p1y;
            r5_div.det_zero  <= r4_det_zero;
            r5_div.nums_zero <= r4_nums_zero;

            r6_div <= n6_div;
        end
    end

    // A quotient of 2^32 or more saturates, so only 32 quotient bits are needed.
    assign lim = {1'b0, r5_div.dvs, 32'b0};

    always_comb begin
        n6_div = r5_div;
        for (int l = 0; l < lnx_pkg::LANES; l++) begin
            n6_div.ovf[l] = (r5_div.rem[l] >= lim);
        end
    end

    assign o_div = r6_div;

endmodule

FILE: src/lnx_div_step.sv
module lnx_div_step #(
    parameter int unsigned SHIFT = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  lnx_pkg::t_div i_div,
    output lnx_pkg::t_div o_div
);

    lnx_pkg::t_div          r_div;
    lnx_pkg::t_div          n_div;
    logic [lnx_pkg::NW-1:0] sh;

    // One restoring step: the divisor shifted to this quotient bit.
    assign sh = {{(lnx_pkg::NW - lnx_pkg::DW){1'b0}}, i_div.dvs} << SHIFT;

    always_comb begin
        n_div = i_div;
        for (int l = 0; l < lnx_pkg::LANES; l++) begin
            if (i_div.rem[l] >= sh) begin
                n_div.rem[l]        = i_div.rem[l] - sh;
                n_div.quo[l][SHIFT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

FILE: src/lnx_back.sv
module lnx_back (
    input  logic          i_clk,
    input  logic          i_en,
    input  lnx_pkg::t_div i_div,
    output lnx_pkg::t_res o_res
);

    logic signed [32:0] r_q [lnx_pkg::LANES];
    logic [3:0]         r_ovf, r_neg;
    logic [31:0]        r_p1x, r_p1y;
    logic               r_det_zero, r_nums_zero;
    lnx_pkg::t_res      r_res;
    lnx_pkg::t_res      n_res;
    logic [31:0]        val [lnx_pkg::LANES];

    function automatic logic [31:0] sat34(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sd2147483647) begin
            r = lnx_pkg::Q_MAX;
        end else if (v < -34'sd2147483648) begin
            r = lnx_pkg::Q_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < lnx_pkg::LANES; l++) begin
                r_q[l] <= i_div.neg[l] ? -$signed({1'b0, i_div.quo[l]})
                                       : $signed({1'b0, i_div.quo[l]});
            end
            r_ovf       <= i_div.ovf;
            r_neg       <= i_div.neg;
            r_p1x       <= i_div.p1x;
            r_p1y       <= i_div.p1y;
            r_det_zero  <= i_div.det_zero;
            r_nums_zero <= i_div.nums_zero;
            r_res       <= n_res;
        end
    end

    always_comb begin
        val[lnx_pkg::LANE_T] = sat34({r_q[lnx_pkg::LANE_T][32], r_q[lnx_pkg::LANE_T]});
        val[lnx_pkg::LANE_S] = sat34({r_q[lnx_pkg::LANE_S][32], r_q[lnx_pkg::LANE_S]});
        val[lnx_pkg::LANE_X] = sat34($signed({{2{r_p1x[31]}}, r_p1x})
                                   + $signed({r_q[lnx_pkg::LANE_X][32], r_q[lnx_pkg::LANE_X]}));
        val[lnx_pkg::LANE_Y] = sat34($signed({{2{r_p1y[31]}}, r_p1y})
                                   + $signed({r_q[lnx_pkg::LANE_Y][32], r_q[lnx_pkg::LANE_Y]}));
        // A quotient of 2^32 or more dominates the start point as well.
        for (int l = 0; l < lnx_pkg::LANES; l++) begin
            if (r_ovf[l]) begin
                val[l] = r_neg[l] ? lnx_pkg::Q_MIN : lnx_pkg::Q_MAX;
            end
        end
        if (r_det_zero) begin
            n_res.status        = r_nums_zero ? lnx_pkg::ST_EQUAL : lnx_pkg::ST_APART;
            n_res.first_factor  = lnx_pkg::MINUS_ONE_Q16;
            n_res.second_factor = lnx_pkg::MINUS_ONE_Q16;
            n_res.hit_x         = '0;
            n_res.hit_y         = '0;
        end else begin
            n_res.status        = lnx_pkg::ST_INTERSECT;
            n_res.first_factor  = val[lnx_pkg::LANE_T];
            n_res.second_factor = val[lnx_pkg::LANE_S];
            n_res.hit_x         = val[lnx_pkg::LANE_X];
            n_res.hit_y         = val[lnx_pkg::LANE_Y];
        end
    end

    assign o_res = r_res;

endmodule

FILE: src/line_intersection_2d_unit.sv
// Intersection of two lines in the plane, each given as a point and a direction in
// signed Q16.16. One result transaction leaves for every input transaction, in order.
// Channels: i_line carries the two lines (valid/ready), o_res carries status, both
// line parameters and the hit point (valid/ready). A transaction moves at a rising
// clock edge where valid and ready are both high.
// Throughput is one transaction per cycle while the skid register is empty. From acceptance
// to the result showing on o_res a transaction passes seven stages of products, cross
// products, magnitudes and dividend assembly, 32 restoring divider stages (one quotient
// bit each, four dividends side by side), two stages of sign, offset and saturation, and
// the output register.
// The pipeline advances as a whole. Behind it sit the output register and a one-entry
// skid register, so a stalled receiver does not stop the next transaction from being
// accepted; only when both are full does i_line.ready drop, and the pipeline holds
// without losing or repeating anything.
// Reset clears all valid bits; the payload registers keep whatever they hold.
module line_intersection_2d_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lnx_in_if.sink    i_line,
    lnx_out_if.source o_res
);

    localparam int unsigned LAST = lnx_pkg::NSTG - 1;

    logic [lnx_pkg::NSTG-1:0] r_vld;
    logic                     en;
    lnx_pkg::t_div            w_div [lnx_pkg::QB+1];
    lnx_pkg::t_res            pipe_res;
    logic                     r_out_vld, r_skid_vld;
    lnx_pkg::t_res            r_out, r_skid;

    // The pipeline only stalls when the skid register is occupied.
    assign en           = !r_skid_vld;
    assign i_line.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAST-1:0], i_line.valid};
        end
    end

    lnx_front u_front (
        .i_clk (i_clk),
        .i_en  (en),
        .i_p1x (i_line.first_point_x),
        .i_p1y (i_line.first_point_y),
        .i_d1x (i_line.first_dir_x),
        .i_d1y (i_line.first_dir_y),
        .i_p2x (i_line.second_point_x),
        .i_p2y (i_line.second_point_y),
        .i_d2x (i_line.second_dir_x),
        .i_d2y (i_line.second_dir_y),
        .o_div (w_div[0])
    );

    // Quotient bits are produced from the most significant down.
    for (genvar g = 0; g < lnx_pkg::QB; g++) begin : g_step
        lnx_div_step #(
            .SHIFT (lnx_pkg::QB - 1 - g)
        ) u_step (
            .i_clk (i_clk),
            .i_en  (en),
            .i_div (w_div[g]),
            .o_div (w_div[g+1])
        );
    end

    lnx_back u_back (
        .i_clk (i_clk),
        .i_en  (en),
        .i_div (w_div[lnx_pkg::QB]),
        .o_res (pipe_res)
    );

    // Output register and skid register. When the pipeline advances, its last stage
    // hands its transaction to the output register if that is free or being taken,
    // and to the skid register otherwise.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (r_skid_vld) begin
                if (o_res.ready) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end
            end else if (r_out_vld && !o_res.ready) begin
                r_skid_vld <= r_vld[LAST];
            end else begin
                r_out_vld <= r_vld[LAST];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (o_res.ready) begin
                r_out <= r_skid;
            end
        end else if (r_out_vld && !o_res.ready) begin
            r_skid <= pipe_res;
        end else begin
            r_out <= pipe_res;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.status        = r_out.status;
    assign o_res.first_factor  = r_out.first_factor;
    assign o_res.second_factor = r_out.second_factor;
    assign o_res.hit_x         = r_out.hit_x;
    assign o_res.hit_y         = r_out.hit_y;

endmodule
